// ----- rtl/dsei_pkg.sv -----
// Shared constants, types and helper functions for the disk stencil E/I update block.
package dsei_pkg;

    // Grid and disk geometry. GRID_SIDE must be a power of two.
    localparam int GRID_SIDE  = 32;
    localparam int EXC_RADIUS = 3;
    localparam int INH_RADIUS = 5;
    localparam int MAX_RADIUS = 7;

    localparam int GRID_BITS = $clog2(GRID_SIDE);
    localparam int NEURONS   = GRID_SIDE * GRID_SIDE;

    // Port widths
    localparam int OPC_W  = 3;
    localparam int IDX_W  = 10;
    localparam int VAL_W  = 16;
    localparam int LEAK_W = 8;
    localparam int UPD_W  = 32;
    localparam logic [LEAK_W-1:0] LEAK_RESET = LEAK_W'(35);

    // Internal widths
    localparam int OFF_W = 4;                 // signed disk offset
    localparam int CRD_W = GRID_BITS + 2;     // signed neighbour coordinate
    localparam int ACT_AW = 2 * GRID_BITS;    // activation memory address
    localparam int PROD_W = 2 * VAL_W;
    localparam int ACC_W  = 40;
    localparam int SELF_W = LEAK_W + VAL_W + 1;
    localparam int LEAK_SHIFT = 10;

    function automatic int disk_size(input int r);
        int n;
        n = 0;
        for (int dr = -r; dr <= r; dr++) begin
            for (int dc = -r; dc <= r; dc++) begin
                if (dr * dr + dc * dc <= r * r) begin
                    n++;
                end
            end
        end
        return n;
    endfunction

    localparam int EXC_DISK = disk_size(EXC_RADIUS);
    localparam int INH_DISK = disk_size(INH_RADIUS);
    localparam int MAX_DISK = (EXC_DISK > INH_DISK) ? EXC_DISK : INH_DISK;
    localparam int EW_AW = $clog2(EXC_DISK);
    localparam int IW_AW = $clog2(INH_DISK);
    localparam int K_W   = $clog2(MAX_DISK);

    // Half width of a disk row at vertical offset dr.
    function automatic logic [OFF_W-2:0] half_ext(input int r,
                                                  input logic signed [OFF_W-1:0] dr);
        logic [OFF_W-2:0] res;
        int d;
        res = '0;
        d = int'(dr);
        for (int h = 0; h <= MAX_RADIUS; h++) begin
            if (h * h + d * d <= r * r) begin
                res = (OFF_W-1)'(h);
            end
        end
        return res;
    endfunction

    typedef enum logic [OPC_W-1:0] {
        OP_EXC_W   = 3'd0,
        OP_INH_W   = 3'd1,
        OP_EXC_A   = 3'd2,
        OP_INH_A   = 3'd3,
        OP_COMPUTE = 3'd4
    } t_opcode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXC,
        S_INH,
        S_DRAIN,
        S_SELF,
        S_FINAL
    } t_state;

    typedef struct packed {
        logic                    wr_ew;
        logic                    wr_iw;
        logic                    wr_ea;
        logic                    wr_ia;
        logic                    start;
        logic                    issue;
        logic                    inh_phase;
        logic                    centre;
        logic signed [OFF_W-1:0] dr;
        logic signed [OFF_W-1:0] dc;
        logic [K_W-1:0]          k;
        logic                    self_mul;
        logic                    finish;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

// ----- rtl/disk_stencil_ei_update.sv -----
// Top level of the disk stencil excitatory/inhibitory neuron update block.
// Write items (weights, activations) leave the input free again in the next cycle.
// A compute transfer passes through S_EXC, S_INH, S_DRAIN, S_SELF and S_FINAL to its result, paced by
// the one-read-per-cycle walk over both disks (one activation memory port per disk).
// A new transfer is taken only once the compute is through; a waiting result does not block writes.
// Reset (i_rst_n low, synchronous): sequencer idle, no result pending, leak back to 35.
module disk_stencil_ei_update (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [dsei_pkg::OPC_W-1:0]          i_opcode,
    input  logic [dsei_pkg::IDX_W-1:0]          i_index,
    input  logic signed [dsei_pkg::VAL_W-1:0]   i_value,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [dsei_pkg::IDX_W-1:0]          o_neuron,
    output logic signed [dsei_pkg::UPD_W-1:0]   o_exc_update,
    output logic signed [dsei_pkg::UPD_W-1:0]   o_inh_update,
    // leak register
    input  logic                                i_cfg_wen,
    input  logic [dsei_pkg::LEAK_W-1:0]         i_cfg_wdata
);

    dsei_pkg::t_dp_cmd    cmd;
    dsei_pkg::t_dp_status status;
    logic                 busy;

    // Sequencer: decodes each input transfer and walks the disks,
    // excitatory first (k = 0..28), then inhibitory (k = 0..80).
    dsei_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .i_index    (i_index),
        .i_status   (status),
        .o_busy     (busy),
        .o_cmd      (cmd)
    );

    // Datapath: memories -> product register -> 40-bit accumulators,
    // then the leak product and a saturating combine into the output register.
    dsei_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_index      (i_index),
        .i_value      (i_value),
        .i_cfg_wen    (i_cfg_wen),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_out_stall  (i_out_stall),
        .o_status     (status),
        .o_out_valid  (o_out_valid),
        .o_neuron     (o_neuron),
        .o_exc_update (o_exc_update),
        .o_inh_update (o_inh_update)
    );

    // Input is only taken while the sequencer is idle.
    assign o_in_stall = busy;

    // A compute on a neuron inside the grid occupies the block.
    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_opcode == dsei_pkg::OP_COMPUTE)
        |=> o_in_stall)
        else $error("compute transfer did not start the sequencer");

    // Table and activation writes never occupy the block.
    a_write_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_opcode != dsei_pkg::OP_COMPUTE)
        |=> !o_in_stall)
        else $error("non-compute transfer left the block busy");

    // A new result only appears at the end of a compute walk.
    a_result_from_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result raised without a compute in flight");

    // The sequencer frees the input in the same cycle it loads a result.
    a_finish_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |=> !o_in_stall && o_out_valid)
        else $error("finish did not return the block to idle");

endmodule

// ----- rtl/dsei_ctrl.sv -----
// Controller: input decode and disk walk sequencer for the E/I stencil update.
module dsei_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic [dsei_pkg::OPC_W-1:0]   i_opcode,
    input  logic [dsei_pkg::IDX_W-1:0]   i_index,
    input  dsei_pkg::t_dp_status         i_status,
    output logic                         o_busy,
    output dsei_pkg::t_dp_cmd            o_cmd
);

    dsei_pkg::t_state r_state, n_state;
    logic signed [dsei_pkg::OFF_W-1:0] r_dr, n_dr, r_dc, n_dc;
    logic [dsei_pkg::K_W-1:0]          r_k, n_k;
    logic                              r_drain, n_drain;

    logic accept;
    logic [dsei_pkg::IDX_W:0] idx_ext;
    logic [dsei_pkg::OFF_W-2:0] h_cur;
    logic [dsei_pkg::OFF_W-2:0] h_next;
    logic [dsei_pkg::OFF_W-2:0] h_inh_first;
    logic [dsei_pkg::OFF_W-2:0] h_exc_first;
    logic signed [dsei_pkg::OFF_W-1:0] dr_inc;

    assign accept  = i_in_valid && (r_state == dsei_pkg::S_IDLE);
    assign idx_ext = {1'b0, i_index};
    assign dr_inc  = r_dr + dsei_pkg::OFF_W'(1);

    always_comb begin
        if (r_state == dsei_pkg::S_INH) begin
            h_cur  = dsei_pkg::half_ext(dsei_pkg::INH_RADIUS, r_dr);
            h_next = dsei_pkg::half_ext(dsei_pkg::INH_RADIUS, dr_inc);
        end else begin
            h_cur  = dsei_pkg::half_ext(dsei_pkg::EXC_RADIUS, r_dr);
            h_next = dsei_pkg::half_ext(dsei_pkg::EXC_RADIUS, dr_inc);
        end
        h_exc_first = dsei_pkg::half_ext(dsei_pkg::EXC_RADIUS,
                                         dsei_pkg::OFF_W'(-dsei_pkg::EXC_RADIUS));
        h_inh_first = dsei_pkg::half_ext(dsei_pkg::INH_RADIUS,
                                         dsei_pkg::OFF_W'(-dsei_pkg::INH_RADIUS));
    end

    // Next state and walk counters
    always_comb begin
        n_state = r_state;
        n_dr    = r_dr;
        n_dc    = r_dc;
        n_k     = r_k;
        n_drain = r_drain;
        unique case (r_state)
            dsei_pkg::S_IDLE: begin
                if (accept && i_opcode == dsei_pkg::OP_COMPUTE &&
                    idx_ext < (dsei_pkg::IDX_W+1)'(dsei_pkg::NEURONS)) begin
                    n_state = dsei_pkg::S_EXC;
                    n_dr    = dsei_pkg::OFF_W'(-dsei_pkg::EXC_RADIUS);
                    n_dc    = -$signed({1'b0, h_exc_first});
                    n_k     = '0;
                end
            end
            dsei_pkg::S_EXC, dsei_pkg::S_INH: begin
                n_k = r_k + dsei_pkg::K_W'(1);
                if (r_dc == $signed({1'b0, h_cur})) begin
                    if (r_state == dsei_pkg::S_EXC &&
                        r_dr == dsei_pkg::OFF_W'(dsei_pkg::EXC_RADIUS)) begin
                        n_state = dsei_pkg::S_INH;
                        n_dr    = dsei_pkg::OFF_W'(-dsei_pkg::INH_RADIUS);
                        n_dc    = -$signed({1'b0, h_inh_first});
                        n_k     = '0;
                    end else if (r_state == dsei_pkg::S_INH &&
                                 r_dr == dsei_pkg::OFF_W'(dsei_pkg::INH_RADIUS)) begin
                        n_state = dsei_pkg::S_DRAIN;
                        n_drain = 1'b0;
                    end else begin
                        n_dr = dr_inc;
                        n_dc = -$signed({1'b0, h_next});
                    end
                end else begin
                    n_dc = r_dc + dsei_pkg::OFF_W'(1);
                end
            end
            dsei_pkg::S_DRAIN: begin
                n_drain = 1'b1;
                if (r_drain) begin
                    n_state = dsei_pkg::S_SELF;
                end
            end
            dsei_pkg::S_SELF: begin
                n_state = dsei_pkg::S_FINAL;
            end
            dsei_pkg::S_FINAL: begin
                if (i_status.out_free) begin
                    n_state = dsei_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dsei_pkg::S_IDLE;
            end
        endcase
    end

    // Command outputs
    always_comb begin
        o_cmd           = '0;
        o_cmd.dr        = r_dr;
        o_cmd.dc        = r_dc;
        o_cmd.k         = r_k;
        o_cmd.inh_phase = (r_state == dsei_pkg::S_INH);
        o_cmd.centre    = (r_dr == '0) && (r_dc == '0);
        o_cmd.issue     = (r_state == dsei_pkg::S_EXC) || (r_state == dsei_pkg::S_INH);
        o_cmd.self_mul  = (r_state == dsei_pkg::S_SELF);
        o_cmd.finish    = (r_state == dsei_pkg::S_FINAL) && i_status.out_free;
        if (accept) begin
            unique case (i_opcode)
                dsei_pkg::OP_EXC_W:
                    o_cmd.wr_ew = idx_ext < (dsei_pkg::IDX_W+1)'(dsei_pkg::EXC_DISK);
                dsei_pkg::OP_INH_W:
                    o_cmd.wr_iw = idx_ext < (dsei_pkg::IDX_W+1)'(dsei_pkg::INH_DISK);
                dsei_pkg::OP_EXC_A:
                    o_cmd.wr_ea = idx_ext < (dsei_pkg::IDX_W+1)'(dsei_pkg::NEURONS);
                dsei_pkg::OP_INH_A:
                    o_cmd.wr_ia = idx_ext < (dsei_pkg::IDX_W+1)'(dsei_pkg::NEURONS);
                dsei_pkg::OP_COMPUTE:
                    o_cmd.start = idx_ext < (dsei_pkg::IDX_W+1)'(dsei_pkg::NEURONS);
                default: ;
            endcase
        end
    end

    assign o_busy = (r_state != dsei_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dsei_pkg::S_IDLE;
            r_dr    <= '0;
            r_dc    <= '0;
            r_k     <= '0;
            r_drain <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dr    <= n_dr;
            r_dc    <= n_dc;
            r_k     <= n_k;
            r_drain <= n_drain;
        end
    end

endmodule

// ----- rtl/dsei_dp.sv -----
// Datapath: weight and activation memories, MAC pipeline, leak term and output register.
module dsei_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dsei_pkg::t_dp_cmd                   i_cmd,
    input  logic [dsei_pkg::IDX_W-1:0]          i_index,
    input  logic signed [dsei_pkg::VAL_W-1:0]   i_value,
    input  logic                                i_cfg_wen,
    input  logic [dsei_pkg::LEAK_W-1:0]         i_cfg_wdata,
    input  logic                                i_out_stall,
    output dsei_pkg::t_dp_status                o_status,
    output logic                                o_out_valid,
    output logic [dsei_pkg::IDX_W-1:0]          o_neuron,
    output logic signed [dsei_pkg::UPD_W-1:0]   o_exc_update,
    output logic signed [dsei_pkg::UPD_W-1:0]   o_inh_update
);

    localparam int GB = dsei_pkg::GRID_BITS;
    localparam int CW = dsei_pkg::CRD_W;

    logic signed [dsei_pkg::VAL_W-1:0] mem_ew [dsei_pkg::EXC_DISK];
    logic signed [dsei_pkg::VAL_W-1:0] mem_iw [dsei_pkg::INH_DISK];
    logic signed [dsei_pkg::VAL_W-1:0] mem_ea [dsei_pkg::NEURONS];
    logic signed [dsei_pkg::VAL_W-1:0] mem_ia [dsei_pkg::NEURONS];

    logic [dsei_pkg::LEAK_W-1:0] r_leak;
    logic [GB-1:0]               r_row, r_col;
    logic [dsei_pkg::IDX_W-1:0]  r_idx;

    logic signed [dsei_pkg::VAL_W-1:0] r_ew_q, r_iw_q, r_ea_q, r_ia_q;
    logic r_v1, r_p1, r_c1, r_v2, r_p2;
    logic signed [dsei_pkg::PROD_W-1:0] r_prod;
    logic signed [dsei_pkg::VAL_W-1:0]  r_self_e, r_self_i;
    logic signed [dsei_pkg::ACC_W-1:0]  r_esum, r_isum;
    logic signed [dsei_pkg::SELF_W-1:0] r_lk_e, r_lk_i;
    logic r_out_valid;

    logic signed [CW-1:0] nr, nc;
    logic                 inb;
    logic [dsei_pkg::ACT_AW-1:0] rd_addr;
    logic [dsei_pkg::ACT_AW-1:0] wr_addr;
    logic signed [dsei_pkg::VAL_W-1:0] w_sel, a_sel;
    logic signed [dsei_pkg::ACC_W-1:0] exc_full, inh_full;

    function automatic logic signed [dsei_pkg::UPD_W-1:0] sat32(
        input logic signed [dsei_pkg::ACC_W-1:0] x);
        logic signed [dsei_pkg::ACC_W-1:0] hi, lo;
        hi = dsei_pkg::ACC_W'(2147483647);
        lo = -dsei_pkg::ACC_W'(2147483647) - dsei_pkg::ACC_W'(1);
        if (x > hi) begin
            return hi[dsei_pkg::UPD_W-1:0];
        end else if (x < lo) begin
            return lo[dsei_pkg::UPD_W-1:0];
        end
        return x[dsei_pkg::UPD_W-1:0];
    endfunction

    // Neighbour coordinates and bounds
    assign nr  = $signed({2'b00, r_row}) + CW'(i_cmd.dr);
    assign nc  = $signed({2'b00, r_col}) + CW'(i_cmd.dc);
    assign inb = (nr >= 0) && (nr < CW'(dsei_pkg::GRID_SIDE)) &&
                 (nc >= 0) && (nc < CW'(dsei_pkg::GRID_SIDE));
    assign rd_addr = {nr[GB-1:0], nc[GB-1:0]};
    assign wr_addr = i_index[dsei_pkg::ACT_AW-1:0];

    // Memories, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_ew) begin
            mem_ew[i_index[dsei_pkg::EW_AW-1:0]] <= i_value;
        end
        r_ew_q <= mem_ew[i_cmd.k[dsei_pkg::EW_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_iw) begin
            mem_iw[i_index[dsei_pkg::IW_AW-1:0]] <= i_value;
        end
        r_iw_q <= mem_iw[i_cmd.k[dsei_pkg::IW_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_ea) begin
            mem_ea[wr_addr] <= i_value;
        end
        r_ea_q <= mem_ea[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_ia) begin
            mem_ia[wr_addr] <= i_value;
        end
        r_ia_q <= mem_ia[rd_addr];
    end

    assign w_sel = r_p1 ? r_iw_q : r_ew_q;
    assign a_sel = r_p1 ? r_ia_q : r_ea_q;

    assign exc_full = r_esum - r_isum -
                      (dsei_pkg::ACC_W'(r_lk_e) <<< dsei_pkg::LEAK_SHIFT);
    assign inh_full = r_esum -
                      (dsei_pkg::ACC_W'(r_lk_i) <<< dsei_pkg::LEAK_SHIFT);

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_row <= i_index[dsei_pkg::ACT_AW-1:GB];
            r_col <= i_index[GB-1:0];
            r_idx <= i_index;
        end
        r_p1   <= i_cmd.inh_phase;
        r_c1   <= i_cmd.centre;
        r_prod <= w_sel * a_sel;
        r_p2   <= r_p1;
        if (r_v1 && r_c1) begin
            if (r_p1) begin
                r_self_i <= r_ia_q;
            end else begin
                r_self_e <= r_ea_q;
            end
        end
        if (i_cmd.self_mul) begin
            r_lk_e <= $signed({1'b0, r_leak}) * r_self_e;
            r_lk_i <= $signed({1'b0, r_leak}) * r_self_i;
        end
        if (i_cmd.finish) begin
            o_neuron     <= r_idx;
            o_exc_update <= sat32(exc_full);
            o_inh_update <= sat32(inh_full);
        end
    end

    // Control and accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leak      <= dsei_pkg::LEAK_RESET;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_esum      <= '0;
            r_isum      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_leak <= i_cfg_wdata;
            end
            r_v1 <= i_cmd.issue && inb;
            r_v2 <= r_v1;
            if (i_cmd.start) begin
                r_esum <= '0;
                r_isum <= '0;
            end else if (r_v2) begin
                if (r_p2) begin
                    r_isum <= r_isum + dsei_pkg::ACC_W'(r_prod);
                end else begin
                    r_esum <= r_esum + dsei_pkg::ACC_W'(r_prod);
                end
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid       = r_out_valid;

endmodule

// ----- tb/dsei_update_checker.sv -----
// Checker for the disk stencil E/I update block: watches both channels, predicts, compares.
module dsei_update_checker
    import dsei_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic [OPC_W-1:0]          i_opcode,
    input  logic [IDX_W-1:0]          i_index,
    input  logic signed [VAL_W-1:0]   i_value,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic [IDX_W-1:0]          i_neuron,
    input  logic signed [UPD_W-1:0]   i_exc_update,
    input  logic signed [UPD_W-1:0]   i_inh_update,
    input  logic                      i_cfg_wen,
    input  logic [LEAK_W-1:0]         i_cfg_wdata,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [IDX_W-1:0]        neuron;
        logic signed [UPD_W-1:0] exc_upd;
        logic signed [UPD_W-1:0] inh_upd;
    } t_update;

    // Shadow copy of the block's tables, grids and leak register
    logic signed [VAL_W-1:0] exc_wt  [EXC_DISK];
    logic signed [VAL_W-1:0] inh_wt  [INH_DISK];
    logic signed [VAL_W-1:0] exc_act [NEURONS];
    logic signed [VAL_W-1:0] inh_act [NEURONS];
    logic [LEAK_W-1:0]       leak_q;

    t_update due_updates[$];
    int      fail_count = 0;
    int      checked    = 0;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        fail_count++;
    endtask

    // Weighted disk sum at Q.18; off-grid neighbours add nothing
    function automatic longint disk_weighted(input bit inh_side, input int row,
                                             input int col);
        int     r;
        int     k;
        int     nr;
        int     nc;
        longint acc;
        r   = inh_side ? INH_RADIUS : EXC_RADIUS;
        acc = 0;
        k   = 0;
        for (int dr = -r; dr <= r; dr++) begin
            for (int dc = -r; dc <= r; dc++) begin
                if (dr * dr + dc * dc <= r * r) begin
                    nr = row + dr;
                    nc = col + dc;
                    if (nr >= 0 && nr < GRID_SIDE && nc >= 0 && nc < GRID_SIDE) begin
                        if (inh_side) begin
                            acc += longint'(inh_wt[k]) * longint'(inh_act[nr * GRID_SIDE + nc]);
                        end else begin
                            acc += longint'(exc_wt[k]) * longint'(exc_act[nr * GRID_SIDE + nc]);
                        end
                    end
                    k++;
                end
            end
        end
        return acc;
    endfunction

    function automatic logic signed [UPD_W-1:0] clamp32(input longint x);
        if (x > longint'(32'sh7FFF_FFFF)) begin
            return 32'sh7FFF_FFFF;
        end else if (x < -longint'(64'sh8000_0000)) begin
            return 32'sh8000_0000;
        end
        return x[UPD_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        t_update want;
        t_update got;
        longint  esum;
        longint  isum;
        longint  eself;
        longint  iself;
        if (!i_rst_n) begin
            leak_q = LEAK_RESET;
            due_updates.delete();
        end else begin
            // result side first: a compute taken at this edge cannot answer at it
            if (i_out_valid && !i_out_stall) begin
                got = '{i_neuron, i_exc_update, i_inh_update};
                if (due_updates.size() == 0) begin
                    report_mismatch($sformatf("unexpected result for neuron %0d", got.neuron));
                end else begin
                    want = due_updates.pop_front();
                    checked++;
                    if (got.neuron !== want.neuron)
                        report_mismatch($sformatf("neuron %0d, want %0d",
                                                  got.neuron, want.neuron));
                    if (got.exc_upd !== want.exc_upd)
                        report_mismatch($sformatf("neuron %0d exc %0d, want %0d",
                                                  want.neuron, got.exc_upd, want.exc_upd));
                    if (got.inh_upd !== want.inh_upd)
                        report_mismatch($sformatf("neuron %0d inh %0d, want %0d",
                                                  want.neuron, got.inh_upd, want.inh_upd));
                end
            end
            if (i_cfg_wen) begin
                leak_q = i_cfg_wdata;
            end
            if (i_in_valid && !i_in_stall) begin
                case (i_opcode)
                    OP_EXC_W: if (i_index < EXC_DISK) exc_wt[i_index] = i_value;
                    OP_INH_W: if (i_index < INH_DISK) inh_wt[i_index] = i_value;
                    OP_EXC_A: if (i_index < NEURONS) exc_act[i_index] = i_value;
                    OP_INH_A: if (i_index < NEURONS) inh_act[i_index] = i_value;
                    OP_COMPUTE: begin
                        if (i_index < NEURONS) begin
                            esum  = disk_weighted(1'b0, i_index / GRID_SIDE, i_index % GRID_SIDE);
                            isum  = disk_weighted(1'b1, i_index / GRID_SIDE, i_index % GRID_SIDE);
                            eself = longint'(leak_q) * longint'(exc_act[i_index]) * 1024;
                            iself = longint'(leak_q) * longint'(inh_act[i_index]) * 1024;
                            want.neuron  = i_index;
                            want.exc_upd = clamp32(esum - isum - eself);
                            want.inh_upd = clamp32(esum - iself);
                            due_updates.push_back(want);
                        end
                    end
                    default: ;
                endcase
            end
        end
        o_pending    = due_updates.size();
        o_fail_count = fail_count;
        o_checked    = checked;
    end

endmodule

// ----- tb/tb_top.sv -----
// Stimulus and verdict for the disk stencil E/I update block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dsei_pkg::*;

    // Settle comfortably past the length of one compute walk.
    localparam int SETTLE_CYCLES = 150;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int HOLD_CYCLES   = 1500;
    localparam int PHASE_ITEMS   = 20;

    // Activations are loaded in two windows only: the top-left one holds the
    // full inhibitory disk of every neuron up to (INH_RADIUS, INH_RADIUS), the
    // bottom-right one the clipped disk of the last neuron.
    localparam int WIN_SIDE    = 2 * INH_RADIUS + 1;
    localparam int CORNER_SIDE = INH_RADIUS + 1;
    localparam logic [IDX_W-1:0] MID_NEURON = IDX_W'(INH_RADIUS * GRID_SIDE + INH_RADIUS);

    logic                     i_clk        = 1'b0;
    logic                     i_rst_n      = 1'b0;
    logic                     i_in_valid   = 1'b0;
    logic                     o_in_stall;
    logic [OPC_W-1:0]         i_opcode     = '0;
    logic [IDX_W-1:0]         i_index      = '0;
    logic signed [VAL_W-1:0]  i_value      = '0;
    logic                     o_out_valid;
    logic                     i_out_stall  = 1'b0;
    logic [IDX_W-1:0]         o_neuron;
    logic signed [UPD_W-1:0]  o_exc_update;
    logic signed [UPD_W-1:0]  o_inh_update;
    logic                     i_cfg_wen    = 1'b0;
    logic [LEAK_W-1:0]        i_cfg_wdata  = '0;

    int chk_fails;
    int chk_pending;
    int chk_checked;

    int gap_pct   = 0;     // chance per cycle that the sender sits idle
    int stall_pct = 0;     // chance per cycle that the receiver stalls
    int hold_left = 0;     // long receiver hold-off, counted down below
    int sent      = 0;
    int cycles    = 0;

    disk_stencil_ei_update uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_opcode     (i_opcode),
        .i_index      (i_index),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_neuron     (o_neuron),
        .o_exc_update (o_exc_update),
        .o_inh_update (o_inh_update),
        .i_cfg_wen    (i_cfg_wen),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    dsei_update_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_opcode     (i_opcode),
        .i_index      (i_index),
        .i_value      (i_value),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_neuron     (o_neuron),
        .i_exc_update (o_exc_update),
        .i_inh_update (o_inh_update),
        .i_cfg_wen    (i_cfg_wen),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (chk_fails),
        .o_pending    (chk_pending),
        .o_checked    (chk_checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, chk_pending);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: random stalls, or a solid hold-off while hold_left runs down.
    // The hold lets the block fill up so that its own input stall gets exercised.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // One input transfer. Valid stays high into the next item when no gap is
    // drawn, so it is never dropped and raised within one step.
    task automatic send_item(input logic [OPC_W-1:0] op, input logic [IDX_W-1:0] idx,
                             input logic signed [VAL_W-1:0] val);
        while ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_index    <= idx;
        i_value    <= val;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sent++;
    endtask

    // Sender pause: drop valid, wait for every result, then let the block go quiet.
    // The first edge lets the checker book the last transfer before we look.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (chk_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Leak register written only with the block idle.
    task automatic write_leak(input logic [LEAK_W-1:0] leak);
        settle();
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= leak;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
    endtask

    // Full-range random values and small magnitudes, with the extremes and zero mixed in.
    function automatic logic signed [VAL_W-1:0] pick_value();
        logic signed [VAL_W-1:0] v;
        case ($urandom_range(7))
            0:       v = 16'sh8000;
            1:       v = 16'sh7FFF;
            2:       v = '0;
            3, 4:    v = VAL_W'($urandom_range(511) - 256);
            default: v = VAL_W'($urandom);
        endcase
        return v;
    endfunction

    // Compute target whose whole disk lies in the loaded windows: clipped at
    // the top and left borders up to a full disk, or the clipped last neuron.
    function automatic logic [IDX_W-1:0] pick_neuron();
        int row;
        int col;
        row = $urandom_range(INH_RADIUS);
        col = $urandom_range(INH_RADIUS);
        if ($urandom_range(3) == 0) begin
            row = GRID_SIDE - 1;
            col = GRID_SIDE - 1;
        end
        return IDX_W'(row * GRID_SIDE + col);
    endfunction

    // Activation slot inside one of the two loaded windows.
    function automatic logic [IDX_W-1:0] pick_act_neuron();
        int base;
        int span;
        int row;
        int col;
        base = 0;
        span = WIN_SIDE;
        if ($urandom_range(3) == 0) begin
            base = GRID_SIDE - CORNER_SIDE;
            span = CORNER_SIDE;
        end
        row = base + $urandom_range(span - 1);
        col = base + $urandom_range(span - 1);
        return IDX_W'(row * GRID_SIDE + col);
    endfunction

    // Both activations of every neuron in a square window on the diagonal.
    task automatic load_window(input int first, input int side);
        for (int r = first; r < first + side; r++) begin
            for (int c = first; c < first + side; c++) begin
                send_item(OP_EXC_A, IDX_W'(r * GRID_SIDE + c), pick_value());
                send_item(OP_INH_A, IDX_W'(r * GRID_SIDE + c), pick_value());
            end
        end
    endtask

    // Random traffic: computes and table/grid writes, with a little noise
    // (out-of-range weight slots, unknown opcodes) that counts for nothing.
    task automatic random_items(input int count);
        int useful;
        int pick;
        useful = 0;
        while (useful < count) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                send_item(OP_COMPUTE, pick_neuron(), VAL_W'($urandom));
                useful++;
            end else if (pick < 60) begin
                send_item(OP_EXC_A, pick_act_neuron(), pick_value());
                useful++;
            end else if (pick < 80) begin
                send_item(OP_INH_A, pick_act_neuron(), pick_value());
                useful++;
            end else if (pick < 87) begin
                send_item(OP_EXC_W, IDX_W'($urandom_range(EXC_DISK - 1)), pick_value());
                useful++;
            end else if (pick < 94) begin
                send_item(OP_INH_W, IDX_W'($urandom_range(INH_DISK - 1)), pick_value());
                useful++;
            end else if (pick < 97) begin
                send_item($urandom_range(1) ? OP_EXC_W : OP_INH_W,
                          IDX_W'($urandom_range(NEURONS - 1, INH_DISK)), pick_value());
            end else begin
                send_item(OPC_W'($urandom_range(7, int'(OP_COMPUTE) + 1)),
                          IDX_W'($urandom), VAL_W'($urandom));
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Load every weight slot and both activation windows first, so that no
        // compute can ever read an entry that was never written.
        for (int k = 0; k < EXC_DISK; k++) send_item(OP_EXC_W, IDX_W'(k), pick_value());
        for (int k = 0; k < INH_DISK; k++) send_item(OP_INH_W, IDX_W'(k), pick_value());
        load_window(0, WIN_SIDE);
        load_window(GRID_SIDE - CORNER_SIDE, CORNER_SIDE);

        // Directed part at the reset leak: both loaded corners and a full disk,
        // ignored writes past the disk sizes, unknown opcodes, then extreme
        // values at the full-disk neuron and at the corners.
        send_item(OP_COMPUTE, 10'd0, '0);
        send_item(OP_COMPUTE, 10'd1023, 16'sh7FFF);
        send_item(OP_COMPUTE, MID_NEURON, 16'sh8000);
        send_item(OP_COMPUTE, IDX_W'(GRID_SIDE + 1), '0);
        send_item(OP_EXC_W, IDX_W'(EXC_DISK), 16'sh1234);
        send_item(OP_INH_W, IDX_W'(INH_DISK), 16'sh7FFF);
        send_item(OP_INH_W, 10'd1023, 16'sh8000);
        for (int op = int'(OP_COMPUTE) + 1; op < 8; op++)
            send_item(OPC_W'(op), 10'd1023, 16'sh8000);
        send_item(OP_EXC_A, MID_NEURON, 16'sh8000);
        send_item(OP_EXC_W, IDX_W'(EXC_DISK / 2), 16'sh8000);
        send_item(OP_INH_A, MID_NEURON, 16'sh7FFF);
        send_item(OP_INH_W, IDX_W'(INH_DISK / 2), 16'sh7FFF);
        send_item(OP_COMPUTE, MID_NEURON, '0);
        send_item(OP_EXC_W, 10'd0, 16'sh7FFF);
        send_item(OP_EXC_A, 10'd0, 16'sh7FFF);
        send_item(OP_INH_A, 10'd1023, 16'sh8000);
        send_item(OP_COMPUTE, 10'd0, '0);
        send_item(OP_COMPUTE, 10'd1023, '0);
        send_item(OP_COMPUTE, IDX_W'(GRID_SIDE + 1), '0);
        send_item(OP_EXC_A, 10'd1023, '0);
        send_item(OP_COMPUTE, 10'd1023, '0);

        // Phase A: full leak, no idling on either side.
        write_leak(8'd255);
        send_item(OP_COMPUTE, MID_NEURON, '0);
        send_item(OP_COMPUTE, 10'd0, '0);
        random_items(PHASE_ITEMS);

        // Long receiver hold-off while computes keep coming: the block fills and
        // must stall its input until the hold ends.
        settle();
        hold_left = HOLD_CYCLES;
        for (int i = 0; i < 4; i++)
            send_item(OP_COMPUTE, pick_neuron(), '0);

        // Phase B: no leak, sender idle more than half the time.
        write_leak(8'd0);
        gap_pct = 53;
        random_items(PHASE_ITEMS);

        // Phase C: random leak, receiver stalling more than half the time.
        write_leak(LEAK_W'($urandom));
        gap_pct   = 0;
        stall_pct = 53;
        random_items(PHASE_ITEMS);

        // Phase D: another random leak, both sides idling.
        write_leak(LEAK_W'($urandom));
        gap_pct   = 32;
        stall_pct = 32;
        random_items(PHASE_ITEMS);

        settle();
        $display("Covered %0d input transfers and %0d checked updates across leak 35, 255, 0",
                 sent, chk_checked);
        $display("and two random values, with sender gaps, receiver stalls and a long hold-off.");
        if (chk_pending != 0)
            $display("%0d expected updates never arrived", chk_pending);
        if (chk_fails == 0 && chk_pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
